>>> rtl/core/rmh_pkg.sv
// shared types and constants for the running median block
package rmh_pkg;

   localparam int CAPACITY   = 1024;
   localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
   localparam int CNT_W      = 11;
   localparam int SAMPLE_W   = 32;
   localparam int MED_W      = 33;

   typedef enum logic {
      HEAP_LO = 1'b0,
      HEAP_UP = 1'b1
   } heap_sel_type;

   typedef enum logic {
      OP_PUSH    = 1'b0,
      OP_REPLACE = 1'b1
   } heap_op_type;

   typedef enum logic [2:0] {
      E_IDLE,
      E_UP_RD,
      E_UP_CMP,
      E_DN_RDL,
      E_DN_RDR,
      E_DN_CMP
   } eng_state_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_OP1,
      S_OP2,
      S_OUT
   } seq_state_type;

   typedef struct packed {
      logic                       start;
      heap_sel_type               sel;
      heap_op_type                op;
      logic signed [SAMPLE_W-1:0] value;
      logic [SIZE_W-1:0]          size;
   } heap_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } heap_stat_type;

   // a ranks above b: greater in the max-heap, smaller in the min-heap
   function automatic logic ranks_above(logic signed [SAMPLE_W-1:0] a,
                                        logic signed [SAMPLE_W-1:0] b,
                                        heap_sel_type sel);
      ranks_above = (sel == HEAP_LO) ? (a > b) : (a < b);
   endfunction

endpackage

>>> rtl/core/rmh_heap_eng.sv
// heap memories and the sift-up / sift-down engine
module rmh_heap_eng (
   input  logic                                clock,
   input  logic                                reset,
   input  rmh_pkg::heap_cmd_type               cmd,
   output rmh_pkg::heap_stat_type              stat,
   output logic signed [rmh_pkg::SAMPLE_W-1:0] lo_top,
   output logic signed [rmh_pkg::SAMPLE_W-1:0] up_top
);
   import rmh_pkg::*;

   logic signed [SAMPLE_W-1:0] lo_mem [HEAP_DEPTH];
   logic signed [SAMPLE_W-1:0] up_mem [HEAP_DEPTH];
   logic signed [SAMPLE_W-1:0] lo_rd_ff, up_rd_ff;

   eng_state_type              state_ff, state_in;
   heap_sel_type               sel_ff, sel_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [SIZE_W-1:0]          size_ff, size_in;
   logic signed [SAMPLE_W-1:0] dl_ff, dl_in;
   logic signed [SAMPLE_W-1:0] top_lo_ff, top_up_ff;

   logic                       re, we;
   logic [IDX_W-1:0]           raddr, waddr;
   logic signed [SAMPLE_W-1:0] wdata, rd;
   logic [IDX_W:0]             lchild, rchild;
   logic [IDX_W-1:0]           parent;
   logic                       r_ok, pick_l, pick_r;
   logic signed [SAMPLE_W-1:0] best_v;

   assign rd     = (sel_ff == HEAP_LO) ? lo_rd_ff : up_rd_ff;
   assign lchild = {idx_ff, 1'b1};
   assign rchild = lchild + 1'b1;
   assign parent = (idx_ff - 1'b1) >> 1;
   assign r_ok   = ({1'b0, rchild} < {1'b0, size_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sel_ff  <= sel_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      size_ff <= size_in;
      dl_ff   <= dl_in;
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      val_in    = val_ff;
      idx_in    = idx_ff;
      size_in   = size_ff;
      dl_in     = dl_ff;
      re        = 1'b0;
      we        = 1'b0;
      raddr     = '0;
      waddr     = idx_ff;
      wdata     = val_ff;
      stat.busy = (state_ff != E_IDLE);
      stat.done = 1'b0;
      pick_l    = 1'b0;
      pick_r    = 1'b0;
      best_v    = val_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               sel_in  = cmd.sel;
               val_in  = cmd.value;
               size_in = cmd.size;
               if (cmd.op == OP_PUSH) begin
                  idx_in   = cmd.size[IDX_W-1:0];
                  state_in = E_UP_RD;
               end else begin
                  idx_in   = '0;
                  state_in = E_DN_RDL;
               end
            end
         end
         E_UP_RD: begin
            if (idx_ff == '0) begin
               we        = 1'b1;
               stat.done = 1'b1;
               state_in  = E_IDLE;
            end else begin
               re       = 1'b1;
               raddr    = parent;
               state_in = E_UP_CMP;
            end
         end
         E_UP_CMP: begin
            we = 1'b1;
            if (ranks_above(val_ff, rd, sel_ff)) begin
               wdata    = rd;
               idx_in   = parent;
               state_in = E_UP_RD;
            end else begin
               stat.done = 1'b1;
               state_in  = E_IDLE;
            end
         end
         E_DN_RDL: begin
            if ({1'b0, lchild} >= {1'b0, size_ff}) begin
               we        = 1'b1;
               stat.done = 1'b1;
               state_in  = E_IDLE;
            end else begin
               re       = 1'b1;
               raddr    = lchild[IDX_W-1:0];
               state_in = E_DN_RDR;
            end
         end
         E_DN_RDR: begin
            dl_in    = rd;
            re       = r_ok;
            raddr    = rchild[IDX_W-1:0];
            state_in = E_DN_CMP;
         end
         E_DN_CMP: begin
            we = 1'b1;
            if (ranks_above(dl_ff, val_ff, sel_ff)) begin
               pick_l = 1'b1;
               best_v = dl_ff;
            end
            if (r_ok && ranks_above(rd, best_v, sel_ff)) begin
               pick_r = 1'b1;
               best_v = rd;
            end
            if (pick_r) begin
               wdata    = rd;
               idx_in   = rchild[IDX_W-1:0];
               state_in = E_DN_RDL;
            end else if (pick_l) begin
               wdata    = dl_ff;
               idx_in   = lchild[IDX_W-1:0];
               state_in = E_DN_RDL;
            end else begin
               stat.done = 1'b1;
               state_in  = E_IDLE;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we && sel_ff == HEAP_LO) begin
         lo_mem[waddr] <= wdata;
      end
      if (we && sel_ff == HEAP_UP) begin
         up_mem[waddr] <= wdata;
      end
      if (re && sel_ff == HEAP_LO) begin
         lo_rd_ff <= lo_mem[raddr];
      end
      if (re && sel_ff == HEAP_UP) begin
         up_rd_ff <= up_mem[raddr];
      end
      if (we && waddr == '0 && sel_ff == HEAP_LO) begin
         top_lo_ff <= wdata;
      end
      if (we && waddr == '0 && sel_ff == HEAP_UP) begin
         top_up_ff <= wdata;
      end
   end

   assign lo_top = top_lo_ff;
   assign up_top = top_up_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == E_IDLE)
      else $error("heap command while engine busy");
   a_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      (re && we) |-> raddr != waddr)
      else $error("read and write of the same heap entry");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> state_ff == E_IDLE)
      else $error("engine not idle after done");
`endif

endmodule

>>> rtl/core/running_median_two_heaps.sv
// running median top level: request sequencer, sizes and result register
//
// req channel: one signed 32-bit sample per request in req_tdata.
// rsp channel: one result per request; rsp_tdata holds twice the median
// (33 bits, one fractional bit) and the stored count (11 bits), rsp_tuser
// flags a sample dropped because the store already holds CAPACITY samples.
// A request is taken only when the sequencer is idle. Each request inserts
// the sample into a max-heap (lower half) or min-heap (upper half) kept in
// two 512-entry synchronous memories; a sift-up reads the parent and then
// compares at each heap level, a sift-down reads the left child, then the
// right child if there is one, and compares. A dropped sample goes straight
// to the result. The longest request moves a top across (a sift-up on one
// heap, then a sift-down on the other); the heap depth bounds its length.
// The result sits in an output register; the next request is accepted while
// it waits, and the sequencer holds a finished result if the receiver stalls.
// Reset empties both heaps at once (sizes cleared, no memory sweep).
module running_median_two_heaps (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [32:0] median_doubled, [43:33] stored_count, zero fill
   output logic        rsp_tuser    // [0] rejected
);
   import rmh_pkg::*;

   seq_state_type              state_ff, state_in;
   logic [SIZE_W-1:0]          lo_size_ff, lo_size_in, up_size_ff, up_size_in;
   logic                       two_ff, two_in;
   logic                       rej_ff, rej_in;
   heap_sel_type               sel2_ff, sel2_in;
   logic signed [SAMPLE_W-1:0] v_ff, v_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MED_W-1:0]    med_ff, med_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_rej_ff, rsp_rej_in;

   heap_cmd_type               cmd;
   heap_stat_type              stat;
   logic signed [SAMPLE_W-1:0] lo_top, up_top, v;
   logic [CNT_W-1:0]           total;
   logic                       accept, rsp_free;

   rmh_heap_eng u_eng (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .lo_top (lo_top),
      .up_top (up_top)
   );

   assign v          = req_tdata;
   assign total      = CNT_W'(lo_size_ff) + CNT_W'(up_size_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lo_size_ff   <= '0;
         up_size_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lo_size_ff   <= lo_size_in;
         up_size_ff   <= up_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      two_ff     <= two_in;
      rej_ff     <= rej_in;
      sel2_ff    <= sel2_in;
      v_ff       <= v_in;
      med_ff     <= med_in;
      cnt_ff     <= cnt_in;
      rsp_rej_ff <= rsp_rej_in;
   end

   always_comb begin
      state_in     = state_ff;
      lo_size_in   = lo_size_ff;
      up_size_in   = up_size_ff;
      two_in       = two_ff;
      rej_in       = rej_ff;
      sel2_in      = sel2_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      med_in       = med_ff;
      cnt_in       = cnt_ff;
      rsp_rej_in   = rsp_rej_ff;
      cmd          = '0;
      cmd.sel      = HEAP_LO;
      cmd.op       = OP_PUSH;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               v_in   = v;
               two_in = 1'b0;
               rej_in = 1'b0;
               if (total >= CNT_W'(CAPACITY)) begin
                  rej_in   = 1'b1;
                  state_in = S_OUT;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_OP1;
                  if (lo_size_ff == up_size_ff) begin
                     if (lo_size_ff == '0 || v < up_top) begin
                        cmd.sel = HEAP_LO;
                     end else begin
                        cmd.sel = HEAP_UP;
                     end
                     cmd.value = v;
                  end else if (up_size_ff > lo_size_ff) begin
                     cmd.sel = HEAP_LO;
                     if (v <= up_top) begin
                        cmd.value = v;
                     end else begin
                        cmd.value = up_top;
                        two_in    = 1'b1;
                        sel2_in   = HEAP_UP;
                     end
                  end else begin
                     cmd.sel = HEAP_UP;
                     if (v >= lo_top) begin
                        cmd.value = v;
                     end else begin
                        cmd.value = lo_top;
                        two_in    = 1'b1;
                        sel2_in   = HEAP_LO;
                     end
                  end
                  if (cmd.sel == HEAP_LO) begin
                     cmd.size   = lo_size_ff;
                     lo_size_in = lo_size_ff + 1'b1;
                  end else begin
                     cmd.size   = up_size_ff;
                     up_size_in = up_size_ff + 1'b1;
                  end
               end
            end
         end
         S_OP1: begin
            if (!stat.busy) begin
               if (two_ff) begin
                  cmd.start = 1'b1;
                  cmd.op    = OP_REPLACE;
                  cmd.sel   = sel2_ff;
                  cmd.value = v_ff;
                  cmd.size  = (sel2_ff == HEAP_LO) ? lo_size_ff : up_size_ff;
                  state_in  = S_OP2;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OP2: begin
            if (stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rej_in   = rej_ff;
               cnt_in       = total;
               if (lo_size_ff == '0 && up_size_ff == '0) begin
                  med_in = '0;
               end else if (lo_size_ff == up_size_ff) begin
                  med_in = MED_W'(lo_top) + MED_W'(up_top);
               end else if (lo_size_ff > up_size_ff) begin
                  med_in = {lo_top, 1'b0};
               end else begin
                  med_in = {up_top, 1'b0};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, cnt_ff, med_ff};
   assign rsp_tuser  = rsp_rej_ff;

`ifndef ASSERT_OFF
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (lo_size_ff <= up_size_ff + 1'b1) && (up_size_ff <= lo_size_ff + 1'b1))
      else $error("heap sizes out of balance");
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");
   a_eng_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !stat.busy)
      else $error("heap engine busy while sequencer idle");
   a_rej_full: assert property (@(posedge clock) disable iff (reset)
      (accept && total >= CNT_W'(CAPACITY)) |=> state_ff == S_OUT && rej_ff)
      else $error("full store did not reject");
`endif

endmodule
